### rtl/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed slot table and its stable key sort.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int OP_W        = 3;
    localparam int KEY_W       = 64;
    localparam int SLOT_W      = 6;
    localparam int POS_W       = 6;
    localparam int FRAME_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ   = 3'd5;
    localparam logic [OP_W-1:0] OP_FRAME  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic flush;
        logic shift;
        logic load;
    } t_chain_ctl;

endpackage

### rtl/kst_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_in_if
// Operation channel: valid, ready and one operation per transaction.
// ----------------------------------------------------------------------------
interface kst_in_if;
    import kst_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key_in;
    logic [SLOT_W-1:0]  slot_in;
    logic [POS_W-1:0]   position_in;
    logic [FRAME_W-1:0] frame_in;

    modport source (output valid, op, key_in, slot_in, position_in, frame_in, input ready);
    modport sink   (input valid, op, key_in, slot_in, position_in, frame_in, output ready);
endinterface

### rtl/kst_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_out_if
// Result channel: valid, ready and one result per transaction.
// ----------------------------------------------------------------------------
interface kst_out_if;
    import kst_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [KEY_W-1:0]    key_out;
    logic [COUNT_W-1:0]  live_count;
    logic                unsorted;

    modport source (output valid, status, slot_out, key_out, live_count, unsorted, input ready);
    modport sink   (input valid, status, slot_out, key_out, live_count, unsorted, output ready);
endinterface

### rtl/kst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_cell
// One sorting cell: keeps the smaller of held and incoming entry, passes the
// other to its right neighbour; shifts left during drain.
// ----------------------------------------------------------------------------
module kst_cell
    import kst_pkg::*;
#(
    parameter int SW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctl       i_ctl,
    input  logic             i_in_v,
    input  logic [KEY_W-1:0] i_in_key,
    input  logic [SW-1:0]    i_in_slot,
    input  logic             i_nb_v,
    input  logic [KEY_W-1:0] i_nb_key,
    input  logic [SW-1:0]    i_nb_slot,
    output logic             o_pass_v,
    output logic [KEY_W-1:0] o_pass_key,
    output logic [SW-1:0]    o_pass_slot,
    output logic             o_held_v,
    output logic [KEY_W-1:0] o_held_key,
    output logic [SW-1:0]    o_held_slot
);

    logic             r_held_v;
    logic [KEY_W-1:0] r_held_key;
    logic [SW-1:0]    r_held_slot;
    logic             r_pass_v;
    logic [KEY_W-1:0] r_pass_key;
    logic [SW-1:0]    r_pass_slot;
    logic             take_in;

    // equal keys fall back to load order, carried in the upper slot bits
    assign take_in = !r_held_v || ({i_in_key, i_in_slot} < {r_held_key, r_held_slot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v <= 1'b0;
            r_pass_v <= 1'b0;
        end else if (i_ctl.flush) begin
            r_held_v <= 1'b0;
            r_pass_v <= 1'b0;
        end else if (i_ctl.shift) begin
            r_held_v <= i_nb_v;
            r_pass_v <= 1'b0;
        end else if (i_in_v) begin
            r_held_v <= 1'b1;
            r_pass_v <= r_held_v;
        end else begin
            r_pass_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_held_key  <= i_nb_key;
            r_held_slot <= i_nb_slot;
        end else if (i_in_v && !i_ctl.flush) begin
            if (take_in) begin
                r_held_key  <= i_in_key;
                r_held_slot <= i_in_slot;
                r_pass_key  <= r_held_key;
                r_pass_slot <= r_held_slot;
            end else begin
                r_pass_key  <= i_in_key;
                r_pass_slot <= i_in_slot;
            end
        end
    end

    assign o_pass_v    = r_pass_v;
    assign o_pass_key  = r_pass_key;
    assign o_pass_slot = r_pass_slot;
    assign o_held_v    = r_held_v;
    assign o_held_key  = r_held_key;
    assign o_held_slot = r_held_slot;

endmodule

### rtl/kst_sort_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_sort_chain
// Row of sorting cells: entries enter at the head one per cycle and settle in
// ascending stable order; a drain shifts them out of the head.
// ----------------------------------------------------------------------------
module kst_sort_chain
    import kst_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int SW       = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chain_ctl       i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  logic [SW-1:0]    i_slot,
    output logic             o_head_v,
    output logic [KEY_W-1:0] o_head_key,
    output logic [SW-1:0]    o_head_slot
);

    logic             pass_v    [CAPACITY];
    logic [KEY_W-1:0] pass_key  [CAPACITY];
    logic [SW-1:0]    pass_slot [CAPACITY];
    logic             held_v    [CAPACITY+1];
    logic [KEY_W-1:0] held_key  [CAPACITY+1];
    logic [SW-1:0]    held_slot [CAPACITY+1];

    assign held_v[CAPACITY]    = 1'b0;
    assign held_key[CAPACITY]  = '0;
    assign held_slot[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic             in_v;
        logic [KEY_W-1:0] in_key;
        logic [SW-1:0]    in_slot;

        if (g == 0) begin : g_head
            assign in_v    = i_ctl.load;
            assign in_key  = i_key;
            assign in_slot = i_slot;
        end else begin : g_body
            assign in_v    = pass_v[g-1];
            assign in_key  = pass_key[g-1];
            assign in_slot = pass_slot[g-1];
        end

        kst_cell #(.SW(SW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_in_v      (in_v),
            .i_in_key    (in_key),
            .i_in_slot   (in_slot),
            .i_nb_v      (held_v[g+1]),
            .i_nb_key    (held_key[g+1]),
            .i_nb_slot   (held_slot[g+1]),
            .o_pass_v    (pass_v[g]),
            .o_pass_key  (pass_key[g]),
            .o_pass_slot (pass_slot[g]),
            .o_held_v    (held_v[g]),
            .o_held_key  (held_key[g]),
            .o_held_slot (held_slot[g])
        );
    end

    assign o_head_v    = held_v[0];
    assign o_head_key  = held_key[0];
    assign o_head_slot = held_slot[0];

endmodule

### rtl/keyed_slot_table_radix_sort_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table_radix_sort_top
// Packet table with slot map, free-slot stack and stable key sort.
// ----------------------------------------------------------------------------
// Operations arrive on i_in, one per transaction; each gives exactly one
// result on o_out. The user must write the ephemeral mode bit (i_cfg_we,
// i_cfg_wdata) only while the block is idle; the block does not enforce it.
// One operation is worked on at a time; i_in.ready is high only between
// operations. Clear, begin_frame and unused codes finish in the first
// state; insert and read_packet take one memory read; update_key reads the
// map and then the packet; remove also reads the last packet to move it
// into the hole, and ends early when the slot is not live.
// The packet, map and free-stack memories have one read port each, which
// sets the step count of the short operations. Sort streams the packets
// through a row of CAPACITY sorting cells and writes them back in order.
// A finished result waits in the output register while the next operation
// is accepted; a further result is held back until o_out.ready takes it.
// Reset empties the table, clears ephemeral mode and sets the last frame id
// to all ones; memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module keyed_slot_table_radix_sort_top
    import kst_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    kst_in_if.sink      i_in,
    kst_out_if.source   o_out
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NW   = $clog2(CAPACITY + 2);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A      = 4'd1;
    localparam logic [3:0] S_B      = 4'd2;
    localparam logic [3:0] S_C      = 4'd3;
    localparam logic [3:0] S_D      = 4'd4;
    localparam logic [3:0] S_LOAD   = 4'd5;
    localparam logic [3:0] S_SETTLE = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SLOT_W-1:0]   r_slot_in, n_slot_in;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [CW-1:0]       r_depth, n_depth;
    logic                r_changed, n_changed;
    logic [FRAME_W-1:0]  r_last_frame, n_last_frame;
    logic                r_eph, n_eph;
    logic [AW-1:0]       r_p, n_p;
    logic [NW-1:0]       r_cnt, n_cnt;
    logic                r_ld_v, n_ld_v;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic [KEY_W-1:0]    r_res_key, n_res_key;
    logic                r_out_v, n_out_v;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [KEY_W-1:0]    r_out_key, n_out_key;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic                r_out_unsorted, n_out_unsorted;

    logic [KEY_W-1:0] mem_key   [CAPACITY];
    logic [AW-1:0]    mem_pslot [CAPACITY];
    logic [AW-1:0]    mem_map   [CAPACITY];
    logic [AW-1:0]    mem_free  [CAPACITY];
    logic [KEY_W-1:0] r_pkt_key_q;
    logic [AW-1:0]    r_pkt_slot_q;
    logic [AW-1:0]    r_map_q;
    logic [AW-1:0]    r_free_q;

    logic             pkt_we, map_we, free_we;
    logic [AW-1:0]    pkt_wa, pkt_ra, map_wa, map_wd, free_wa, free_wd;
    logic [KEY_W-1:0] pkt_wkey;
    logic [AW-1:0]    pkt_wslot;
    logic [AW-1:0]    ins_slot;
    logic [AW-1:0]    last_pos;

    t_chain_ctl       chain_ctl;
    logic [2*AW-1:0]  chain_slot;
    logic             head_v;
    logic [KEY_W-1:0] head_key;
    logic [2*AW-1:0]  head_slot;

    always_ff @(posedge i_clk) begin
        if (pkt_we) begin
            mem_key[pkt_wa]   <= pkt_wkey;
            mem_pslot[pkt_wa] <= pkt_wslot;
        end
        r_pkt_key_q  <= mem_key[pkt_ra];
        r_pkt_slot_q <= mem_pslot[pkt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        r_map_q <= mem_map[AW'(r_slot_in)];
    end

    always_ff @(posedge i_clk) begin
        if (free_we) begin
            mem_free[free_wa] <= free_wd;
        end
        r_free_q <= mem_free[AW'(r_depth - CW'(1))];
    end

    // load position in the upper bits orders equal keys
    assign chain_slot = {AW'(r_cnt - NW'(1)), r_pkt_slot_q};

    kst_sort_chain #(.CAPACITY(CAPACITY), .SW(2 * AW)) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (chain_ctl),
        .i_key       (r_pkt_key_q),
        .i_slot      (chain_slot),
        .o_head_v    (head_v),
        .o_head_key  (head_key),
        .o_head_slot (head_slot)
    );

    assign last_pos = AW'(r_total - CW'(1));

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_key          = r_key;
        n_slot_in      = r_slot_in;
        n_pos          = r_pos;
        n_frame        = r_frame;
        n_total        = r_total;
        n_fresh        = r_fresh;
        n_depth        = r_depth;
        n_changed      = r_changed;
        n_last_frame   = r_last_frame;
        n_eph          = r_eph;
        n_p            = r_p;
        n_cnt          = r_cnt;
        n_ld_v         = 1'b0;
        n_status       = r_status;
        n_res_slot     = r_res_slot;
        n_res_key      = r_res_key;
        n_out_v        = r_out_v;
        n_out_status   = r_out_status;
        n_out_slot     = r_out_slot;
        n_out_key      = r_out_key;
        n_out_count    = r_out_count;
        n_out_unsorted = r_out_unsorted;
        pkt_we         = 1'b0;
        pkt_wa         = '0;
        pkt_wkey       = r_key;
        pkt_wslot      = '0;
        pkt_ra         = AW'(r_pos);
        map_we         = 1'b0;
        map_wa         = '0;
        map_wd         = '0;
        free_we        = 1'b0;
        free_wa        = AW'(r_depth);
        free_wd        = AW'(r_slot_in);
        ins_slot       = r_free_q;
        chain_ctl      = '{flush: 1'b0, shift: 1'b0, load: r_ld_v};

        if (o_out.ready) begin
            n_out_v = 1'b0;
        end
        if (i_cfg_we) begin
            n_eph = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op      = i_in.op;
                    n_key     = i_in.key_in;
                    n_slot_in = i_in.slot_in;
                    n_pos     = i_in.position_in;
                    n_frame   = i_in.frame_in;
                    n_state   = S_A;
                end
            end
            S_A: begin
                n_status   = ST_OK;
                n_res_slot = '0;
                n_res_key  = '0;
                n_state    = S_OUT;
                case (r_op) inside
                    OP_CLEAR: begin
                        n_total   = '0;
                        n_fresh   = '0;
                        n_depth   = '0;
                        n_changed = 1'b0;
                    end
                    OP_FRAME: begin
                        if (r_frame != r_last_frame) begin
                            n_last_frame = r_frame;
                            if (r_eph) begin
                                n_total   = '0;
                                n_fresh   = '0;
                                n_depth   = '0;
                                n_changed = 1'b0;
                            end
                        end
                    end
                    OP_SORT: begin
                        chain_ctl.flush = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_LOAD;
                    end
                    OP_INSERT, OP_REMOVE, OP_UPDATE, OP_READ: begin
                        n_state = S_B;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_B: begin
                n_state = S_OUT;
                case (r_op)
                    OP_INSERT: begin
                        if (32'(r_total) >= CAPACITY) begin
                            n_status = ST_FULL;
                        end else if (r_depth != '0 || 32'(r_fresh) < CAPACITY) begin
                            if (r_depth != '0) begin
                                ins_slot = r_free_q;
                                n_depth  = r_depth - CW'(1);
                            end else begin
                                ins_slot = AW'(r_fresh);
                                n_fresh  = r_fresh + CW'(1);
                            end
                            pkt_we     = 1'b1;
                            pkt_wa     = AW'(r_total);
                            pkt_wslot  = ins_slot;
                            map_we     = 1'b1;
                            map_wa     = ins_slot;
                            map_wd     = AW'(r_total);
                            n_total    = r_total + CW'(1);
                            n_changed  = 1'b1;
                            n_res_slot = SLOT_W'(ins_slot);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                    OP_READ: begin
                        if (32'(r_pos) >= 32'(r_total)) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_res_key  = r_pkt_key_q;
                            n_res_slot = SLOT_W'(r_pkt_slot_q);
                        end
                    end
                    default: begin
                        if (32'(r_slot_in) < 32'(r_fresh) && 32'(r_map_q) < 32'(r_total)) begin
                            n_p     = r_map_q;
                            pkt_ra  = r_map_q;
                            n_state = S_C;
                        end else begin
                            n_status = ST_INVALID;
                        end
                    end
                endcase
            end
            S_C: begin
                n_state = S_OUT;
                if (32'(r_pkt_slot_q) != 32'(r_slot_in)) begin
                    n_status = ST_INVALID;
                end else if (r_op == OP_UPDATE) begin
                    pkt_we    = 1'b1;
                    pkt_wa    = r_p;
                    pkt_wkey  = r_key;
                    pkt_wslot = r_pkt_slot_q;
                    n_changed = 1'b1;
                end else if (32'(r_depth) >= CAPACITY) begin
                    n_status = ST_INVALID;
                end else begin
                    pkt_ra  = last_pos;
                    n_state = S_D;
                end
            end
            S_D: begin
                if (r_p != last_pos) begin
                    pkt_we    = 1'b1;
                    pkt_wa    = r_p;
                    pkt_wkey  = r_pkt_key_q;
                    pkt_wslot = r_pkt_slot_q;
                    map_we    = 1'b1;
                    map_wa    = r_pkt_slot_q;
                    map_wd    = r_p;
                end
                free_we   = 1'b1;
                n_depth   = r_depth + CW'(1);
                n_total   = r_total - CW'(1);
                n_changed = 1'b1;
                n_state   = S_OUT;
            end
            S_LOAD: begin
                if (32'(r_cnt) < 32'(r_total)) begin
                    pkt_ra = AW'(r_cnt);
                    n_cnt  = r_cnt + NW'(1);
                    n_ld_v = 1'b1;
                end else begin
                    n_cnt   = '0;
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (32'(r_cnt) == CAPACITY + 1) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            S_DRAIN: begin
                if (32'(r_cnt) < 32'(r_total)) begin
                    pkt_we          = 1'b1;
                    pkt_wa          = AW'(r_cnt);
                    pkt_wkey        = head_key;
                    pkt_wslot       = head_slot[AW-1:0];
                    map_we          = 1'b1;
                    map_wa          = head_slot[AW-1:0];
                    map_wd          = AW'(r_cnt);
                    chain_ctl.shift = 1'b1;
                    n_cnt           = r_cnt + NW'(1);
                end else begin
                    n_changed = 1'b0;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_v || o_out.ready) begin
                    n_out_v        = 1'b1;
                    n_out_status   = r_status;
                    n_out_slot     = r_res_slot;
                    n_out_key      = r_res_key;
                    n_out_count    = COUNT_W'(r_total);
                    n_out_unsorted = r_changed;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_fresh      <= '0;
            r_depth      <= '0;
            r_changed    <= 1'b0;
            r_last_frame <= '1;
            r_eph        <= 1'b0;
            r_cnt        <= '0;
            r_ld_v       <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_fresh      <= n_fresh;
            r_depth      <= n_depth;
            r_changed    <= n_changed;
            r_last_frame <= n_last_frame;
            r_eph        <= n_eph;
            r_cnt        <= n_cnt;
            r_ld_v       <= n_ld_v;
            r_out_v      <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_key          <= n_key;
        r_slot_in      <= n_slot_in;
        r_pos          <= n_pos;
        r_frame        <= n_frame;
        r_p            <= n_p;
        r_status       <= n_status;
        r_res_slot     <= n_res_slot;
        r_res_key      <= n_res_key;
        r_out_status   <= n_out_status;
        r_out_slot     <= n_out_slot;
        r_out_key      <= n_out_key;
        r_out_count    <= n_out_count;
        r_out_unsorted <= n_out_unsorted;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_v;
    assign o_out.status     = r_out_status;
    assign o_out.slot_out   = r_out_slot;
    assign o_out.key_out    = r_out_key;
    assign o_out.live_count = r_out_count;
    assign o_out.unsorted   = r_out_unsorted;

    // every handed-out slot is either live or on the free stack
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_depth) + 32'(r_total) == 32'(r_fresh)))
        else $error("slot accounting broken");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_total) <= CAPACITY))
        else $error("packet count beyond capacity");

    // chain must hold every packet once settling is over
    a_drain_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && 32'(r_cnt) < 32'(r_total)) |-> head_v)
        else $error("sort chain ran dry during drain");

    a_sort_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && 32'(r_cnt) >= 32'(r_total)) |=> !r_changed)
        else $error("sort left table marked unsorted");

endmodule
